// ===== rtl/core/dpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpf_pkg: shared types and constants of the duplicate packet filter
// The triple layout, the filter control states and the probe token that
// travels down the history chain.
// ----------------------------------------------------------------------------
package dpf_pkg;

  localparam int BYTE_W   = 8;
  localparam int TRIPLE_W = 3 * BYTE_W;
  localparam int IN_W     = 4 * BYTE_W;
  localparam int OUT_W    = 8;

  localparam logic REG_OWN_ADDRESS   = 1'b0;
  localparam logic REG_RELAY_ADDRESS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } dpf_state_t;

  // Search token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [TRIPLE_W-1:0] key;
  } dpf_probe_t;

endpackage

// ===== rtl/core/dpf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpf_cell: one history entry of the duplicate packet filter
// Holds one (source, destination, sequence) triple, matches it against the
// probe that passes through, and shifts its entry to the next cell on insert.
// ----------------------------------------------------------------------------
module dpf_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             shift_en,
  input  logic [dpf_pkg::TRIPLE_W-1:0]     entry_in,
  output logic [dpf_pkg::TRIPLE_W-1:0]     entry_out,
  input  dpf_pkg::dpf_probe_t              probe_in,
  output dpf_pkg::dpf_probe_t              probe_out
);
  import dpf_pkg::*;

  logic [TRIPLE_W-1:0] entry;
  dpf_probe_t          probe;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift_en) begin
      entry <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe.valid <= 1'b0;
    end else begin
      probe.valid <= probe_in.valid;
    end
    probe.hit <= probe_in.hit | (probe_in.key == entry);
    probe.key <= probe_in.key;
  end

  assign entry_out = entry;
  assign probe_out = probe;

endmodule

// ===== rtl/core/duplicate_packet_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_packet_filter: drops repeated radio packet headers
// Checks the destination of each header beat, searches its triple in a
// shifting chain of history cells and inserts it when it is not found.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// s_*       in   tdata: source, destination, sequence, length (8 bits each)
// m_*       out  tdata: ack_request, new_packet, zero fill
// cfg_*     in   write of own_address (index 0) or relay_address (index 1)
//
// A header that passes the address check sends a probe down the cell chain,
// which walks it one cell a cycle, before the next header is accepted; a
// rejected or empty header skips the search and goes straight to ST_DONE.
// Reset clears every history cell at once; no clearing pass follows.
// A result waiting on m_tready does not block the next header beat, but that
// header's result is loaded only once the output register is free.
// ----------------------------------------------------------------------------
module duplicate_packet_filter #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [7:0] source_address, [15:8] destination_address,
  // [23:16] sequence_number, [31:24] packet_length
  input  logic [dpf_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [0] ack_request, [1] new_packet, [7:2] zero
  output logic [dpf_pkg::OUT_W-1:0]    m_tdata,
  input  logic                         cfg_wen,
  input  logic                         cfg_index,
  input  logic [dpf_pkg::BYTE_W-1:0]   cfg_data
);
  import dpf_pkg::*;

  dpf_state_t          state, state_next;
  logic [BYTE_W-1:0]   own_address;
  logic [BYTE_W-1:0]   relay_address;
  logic [TRIPLE_W-1:0] key_q;
  logic                ack_q;
  logic                hit_q;
  logic                launch;
  logic                accept;
  logic                eligible;
  logic                out_free;
  logic                load_out;
  logic                shift_en;
  logic                ack_bit;
  logic                new_bit;

  dpf_probe_t          probe [0:HISTORY_DEPTH];
  logic [TRIPLE_W-1:0] entry [0:HISTORY_DEPTH-1];

  assign accept   = s_tvalid && s_tready;
  assign eligible = (s_tdata[31:24] != '0) &&
                    ((s_tdata[15:8] == own_address) || (relay_address != '0));
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= '0;
      relay_address <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_OWN_ADDRESS:   own_address   <= cfg_data;
        REG_RELAY_ADDRESS: relay_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = eligible ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (probe[HISTORY_DEPTH].valid) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  assign shift_en = load_out && ack_q && !hit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept && eligible;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= s_tdata[TRIPLE_W-1:0];
      ack_q <= eligible;
      hit_q <= 1'b0;
    end else if (state == ST_SCAN && probe[HISTORY_DEPTH].valid) begin
      hit_q <= probe[HISTORY_DEPTH].hit;
    end
  end

  // The newest triple enters at cell 0; the oldest falls off the far end,
  // which is the same replacement order as a ring pointer.
  assign probe[0].valid = launch;
  assign probe[0].hit   = 1'b0;
  assign probe[0].key   = key_q;

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic [TRIPLE_W-1:0] entry_prev;
    if (i == 0) begin : g_head
      assign entry_prev = key_q;
    end else begin : g_body
      assign entry_prev = entry[i-1];
    end
    dpf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (shift_en),
      .entry_in  (entry_prev),
      .entry_out (entry[i]),
      .probe_in  (probe[i]),
      .probe_out (probe[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ack_bit <= ack_q;
      new_bit <= ack_q && !hit_q;
    end
  end

  assign m_tdata = {{(OUT_W-2){1'b0}}, new_bit, ack_bit};

`ifndef NO_ASSERTIONS
  a_launch_in_scan: assert property (@(posedge clk) disable iff (rst)
    launch |-> state == ST_SCAN)
    else $error("probe launched outside a search");

  a_probe_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    probe[HISTORY_DEPTH].valid |-> state == ST_SCAN)
    else $error("probe left the chain outside a search");

  a_shift_only_new: assert property (@(posedge clk) disable iff (rst)
    shift_en |-> (state == ST_DONE && ack_q && !hit_q && out_free))
    else $error("history shifted without a new packet");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("filter stayed idle after a header beat");

  a_new_implies_ack: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
    else $error("new packet flagged without an acknowledgement");
`endif

endmodule
